@@ rtl/fcc_pkg.sv @@
// ----------------------------------------------------------------------------
// fcc_pkg
// shared types and constants of the cyclic convolution block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fcc_pkg;

	localparam int IDX_W     = 6;   // result index width, n never exceeds 64
	localparam int ACC_W     = 38;  // result value width
	localparam int IN_FLD_W  = 16;  // width of each coefficient field on the port
	localparam int IN_DATA_W = 32;
	localparam int OUT_DATA_W = 48;

	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic             rd_en;
		logic             use_b;
		logic [IDX_W-1:0] rd_addr_a;
		logic [IDX_W-1:0] rd_addr_b;
		logic             load_out;
		logic [IDX_W-1:0] out_index;
		logic             out_last;
		logic             out_ovf;
	} fcc_cmd_t;

	typedef struct packed {
		logic busy;
		logic out_free;
	} fcc_stat_t;

endpackage

`default_nettype wire

@@ rtl/fcc_ctrl.sv @@
// ----------------------------------------------------------------------------
// fcc_ctrl
// sequencer: load counting, multiply-accumulate schedule, result release
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fcc_ctrl #(
	parameter int MAX_N = 64
) (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                logic in_valid,
	input  wire                logic in_last,
	output logic               in_ready,
	output fcc_pkg::fcc_cmd_t  cmd,
	input  fcc_pkg::fcc_stat_t stat
);
	import fcc_pkg::*;

	localparam int CW = $clog2(MAX_N + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_PUSH} state_t;

	state_t           state_q;
	logic [CW-1:0]    cnt_q;
	logic             drop_q;
	logic [IDX_W-1:0] k_q;
	logic [CW-1:0]    i_q;

	logic             accept;
	logic [IDX_W:0]   cm1;
	logic [IDX_W-1:0] nmask;
	logic [IDX_W-1:0] j;
	logic             room;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign room     = cnt_q < CW'(MAX_N);

	// mask n-1 from the count: smear the top set bit of count-1 downward
	always_comb begin
		logic [IDX_W-1:0] m;
		cm1 = (IDX_W+1)'(cnt_q) - (IDX_W+1)'(1);
		m = cm1[IDX_W-1:0];
		m = m | (m >> 1);
		m = m | (m >> 2);
		m = m | (m >> 4);
		nmask = m;
	end

	assign j = (k_q - IDX_W'(i_q)) & nmask;

	always_comb begin
		cmd           = '0;
		cmd.wr_en     = accept && room;
		cmd.wr_addr   = IDX_W'(cnt_q);
		cmd.rd_en     = (state_q == ST_RUN);
		cmd.rd_addr_a = IDX_W'(i_q);
		cmd.rd_addr_b = j;
		// positions past the loaded count are zero padding
		cmd.use_b     = (IDX_W+1)'(j) < (IDX_W+1)'(cnt_q);
		cmd.load_out  = (state_q == ST_PUSH) && stat.out_free;
		cmd.out_index = k_q;
		cmd.out_last  = (k_q == nmask);
		cmd.out_ovf   = drop_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			drop_q  <= 1'b0;
			k_q     <= '0;
			i_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (room) cnt_q <= cnt_q + CW'(1);
						else drop_q <= 1'b1;
						if (in_last) begin
							state_q <= ST_RUN;
							k_q     <= '0;
							i_q     <= '0;
						end
					end
				end
				ST_RUN: begin
					i_q <= i_q + CW'(1);
					if (i_q == cnt_q - CW'(1)) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (!stat.busy) state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (stat.out_free) begin
						if (k_q == nmask) begin
							state_q <= ST_IDLE;
							cnt_q   <= '0;
							drop_q  <= 1'b0;
						end else begin
							state_q <= ST_RUN;
							k_q     <= k_q + IDX_W'(1);
							i_q     <= '0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/fcc_dp.sv @@
// ----------------------------------------------------------------------------
// fcc_dp
// coefficient stores, multiply-accumulate pipeline and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fcc_dp #(
	parameter int MAX_N     = 64,
	parameter int COEF_BITS = 16
) (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                logic [fcc_pkg::IN_DATA_W-1:0] in_data,
	input  fcc_pkg::fcc_cmd_t  cmd,
	output fcc_pkg::fcc_stat_t stat,
	output logic               out_valid,
	input  wire                logic out_ready,
	output logic [fcc_pkg::OUT_DATA_W-1:0] out_data,
	output logic               out_last,
	output logic               out_ovf
);
	import fcc_pkg::*;

	localparam int AW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
	localparam int PW = 2 * COEF_BITS;

	logic signed [COEF_BITS-1:0] mem_a [MAX_N];
	logic signed [COEF_BITS-1:0] mem_b [MAX_N];

	logic signed [COEF_BITS-1:0] a_s1, b_s1;
	logic                        v_s1, use_s1;
	logic signed [PW-1:0]        prod_s2;
	logic                        v_s2;
	logic signed [ACC_W-1:0]     acc_q;

	logic                        ov_q;
	logic [IDX_W-1:0]            idx_q;
	logic [ACC_W-1:0]            val_q;
	logic                        last_q, ovf_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_a[cmd.wr_addr[AW-1:0]] <= in_data[COEF_BITS-1:0];
			mem_b[cmd.wr_addr[AW-1:0]] <= in_data[IN_FLD_W+COEF_BITS-1:IN_FLD_W];
		end
		a_s1   <= mem_a[cmd.rd_addr_a[AW-1:0]];
		b_s1   <= mem_b[cmd.rd_addr_b[AW-1:0]];
		use_s1 <= cmd.use_b;
		if (use_s1) prod_s2 <= a_s1 * b_s1;
		else prod_s2 <= '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) acc_q <= '0;
		else if (cmd.load_out) acc_q <= '0;
		else if (v_s2) acc_q <= acc_q + ACC_W'(prod_s2);
	end

	assign stat.busy     = v_s1 || v_s2;
	assign stat.out_free = !ov_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.load_out) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			idx_q  <= cmd.out_index;
			val_q  <= acc_q;
			last_q <= cmd.out_last;
			ovf_q  <= cmd.out_ovf;
		end
	end

	assign out_valid = ov_q;
	assign out_data  = {{(OUT_DATA_W-ACC_W-IDX_W){1'b0}}, val_q, idx_q};
	assign out_last  = last_q;
	assign out_ovf   = ovf_q;

endmodule

`default_nettype wire

@@ rtl/fft_cyclic_convolution.sv @@
// ----------------------------------------------------------------------------
// fft_cyclic_convolution
// exact integer cyclic convolution of two loaded coefficient sequences
// ----------------------------------------------------------------------------
// Coefficient pairs load at one request per cycle; the request with tlast
// starts a run over n = next power of two of the pair count c. Each of the n
// results is formed by one shared multiply-accumulate unit reading both
// coefficient memories once per cycle; no new pair is accepted during a run.
// Pairs beyond MAX_N are dropped and reported on tuser of every result.
`timescale 1ns / 1ps
`default_nettype none

module fft_cyclic_convolution #(
	parameter int MAX_N     = 64,
	parameter int COEF_BITS = 16
) (
	input  wire  logic        clk,
	input  wire  logic        arst_n,
	input  wire  logic        s_tvalid,
	output logic              s_tready,
	input  wire  logic [31:0] s_tdata,  // coef_a, coef_b
	input  wire  logic        s_tlast,  // last_item
	output logic              m_tvalid,
	input  wire  logic        m_tready,
	output logic [47:0]       m_tdata,  // result_index, result_value, zero fill
	output logic              m_tlast,  // last_result
	output logic              m_tuser   // overflow
);
	import fcc_pkg::*;

	fcc_cmd_t  cmd;
	fcc_stat_t stat;

	fcc_ctrl #(.MAX_N(MAX_N)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	fcc_dp #(.MAX_N(MAX_N), .COEF_BITS(COEF_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_last  (m_tlast),
		.out_ovf   (m_tuser)
	);

endmodule

`default_nettype wire

@@ rtl/fcc_checker.sv @@
// ----------------------------------------------------------------------------
// fcc_checker
// port-level checks of the cyclic convolution block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fcc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [31:0] s_tdata,
	input wire logic        s_tlast,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [47:0] m_tdata,
	input wire logic        m_tlast,
	input wire logic        m_tuser
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	// last index is n-1 with n a power of two
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> ((m_tdata[5:0] & (m_tdata[5:0] + 6'd1)) == 6'd0))
		else $error("last result index not n-1");

	// no loading while a run is still producing
	a_no_load: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input ready during run");

endmodule

bind fft_cyclic_convolution fcc_checker u_fcc_checker (.*);

`default_nettype wire

@@ test/tb_fft_cyclic_convolution.sv @@
// ----------------------------------------------------------------------------
// tb_fft_cyclic_convolution
// self-checking bench for the cyclic convolution block
// ----------------------------------------------------------------------------
// Coefficient pairs are streamed in runs closed by tlast. A local predictor
// forms the exact integer cyclic convolution of each run. Every result request
// is compared field by field with the oldest expected one. Both sides idle at
// random, and one long output stall fills the block and backs up its input.
`timescale 1ns / 1ps

module tb_fft_cyclic_convolution;
	import fcc_pkg::*;

	localparam int MAX_PAIRS = 64;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct {
		logic [IDX_W-1:0] index;
		logic [ACC_W-1:0] value;
		logic             last;
		logic             ovf;
	} conv_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic m_tlast;
	logic m_tuser;

	fft_cyclic_convolution dut (.*);

	// predictor state
	logic signed [15:0] seq_a [MAX_PAIRS];
	logic signed [15:0] seq_b [MAX_PAIRS];
	int pair_count = 0;
	bit pairs_dropped = 0;
	conv_result_t expected_results[$];

	int errors = 0;
	int runs_sent = 0;
	int results_seen = 0;
	longint cycles = 0;
	bit hold_output = 0;

	initial forever #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout at %0t", $time);
			$display("Mismatches found");
			$finish;
		end
	end

	// predict the results of one closed run
	task automatic predict_convolution();
		longint acc [64];
		int n;
		conv_result_t r;
		n = 1;
		while (n < pair_count) n = n << 1;
		for (int k = 0; k < 64; k++) acc[k] = 0;
		for (int i = 0; i < pair_count; i++)
			for (int j = 0; j < pair_count; j++)
				acc[(i + j) & (n - 1)] += longint'(seq_a[i]) * longint'(seq_b[j]);
		for (int k = 0; k < n; k++) begin
			r.index = k[IDX_W-1:0];
			r.value = acc[k][ACC_W-1:0];
			r.last = (k == n - 1);
			r.ovf = pairs_dropped;
			expected_results.push_back(r);
		end
		pair_count = 0;
		pairs_dropped = 0;
		runs_sent++;
	endtask

	task automatic send_pair(input logic [15:0] a, input logic [15:0] b, input bit last,
			input bit gaps);
		int gap;
		gap = 0;
		if (gaps) gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {b, a};
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (pair_count < MAX_PAIRS) begin
			seq_a[pair_count] = a;
			seq_b[pair_count] = b;
			pair_count++;
		end else begin
			pairs_dropped = 1;
		end
		if (last) predict_convolution();
	endtask

	task automatic send_run(input int len, input bit gaps, input int mode);
		logic [15:0] a, b;
		for (int i = 0; i < len; i++) begin
			case (mode)
				1: begin a = 16'h7fff; b = 16'h7fff; end
				2: begin a = 16'h8000; b = 16'h8000; end
				3: begin a = 16'h8000; b = 16'h7fff; end
				default: begin a = 16'($urandom); b = 16'($urandom); end
			endcase
			send_pair(a, b, i == len - 1, gaps);
		end
	endtask

	// output side: random stalls, or a long hold when requested
	always @(posedge clk) begin
		if (!arst_n) m_tready <= 1'b0;
		else if (hold_output) m_tready <= 1'b0;
		else if ($urandom_range(0, 15) == 0) m_tready <= 1'b0;
		else if ($urandom_range(0, 2) == 0) m_tready <= 1'b1;
	end

	always @(posedge clk) begin
		conv_result_t e;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, m_tdata);
				errors++;
			end else begin
				e = expected_results.pop_front();
				if (m_tdata[IDX_W-1:0] !== e.index || m_tdata[IDX_W+ACC_W-1:IDX_W] !== e.value
						|| m_tlast !== e.last || m_tuser !== e.ovf || m_tdata[47:44] !== 4'd0) begin
					$display("%0t: expected idx %0d val %h last %b ovf %b, got idx %0d val %h last %b ovf %b",
						$time, e.index, e.value, e.last, e.ovf, m_tdata[IDX_W-1:0],
						m_tdata[IDX_W+ACC_W-1:IDX_W], m_tlast, m_tuser);
					errors++;
				end
			end
		end
	end

	task automatic test_extremes();
		send_run(1, 1'b0, 0);
		send_run(1, 1'b0, 1);
		send_run(2, 1'b0, 2);
		send_run(3, 1'b0, 3);
		send_run(5, 1'b0, 0);
		send_run(8, 1'b0, 1);
	endtask

	task automatic test_full_store();
		send_run(64, 1'b0, 2);
		send_run(66, 1'b1, 0);
		send_run(64, 1'b1, 1);
	endtask

	task automatic test_backpressure();
		int hold;
		hold_output = 1;
		fork
			begin
				send_run(4, 1'b0, 0);
				send_run(3, 1'b0, 0);
				send_run(2, 1'b0, 0);
			end
			begin
				hold = 0;
				while (hold < 300) begin
					@(posedge clk);
					hold++;
				end
				hold_output = 0;
			end
		join
	endtask

	task automatic test_random();
		int sent, len;
		sent = 0;
		while (sent < 240) begin
			len = ($urandom_range(0, 19) == 0) ? $urandom_range(33, 70) : $urandom_range(1, 12);
			send_run(len, 1'b1, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
			sent += len;
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_full_store();
		test_backpressure();
		test_random();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("%0d runs sent, %0d results checked, including full-store and stall cases",
			runs_sent, results_seen);
		if (errors == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

endmodule
